/* rtl/mf_pkg.sv */
// Package for the 3x3 median filter: widths, register indexes and the
// queue word type shared by the front end, queue and back end.
// No dependencies.
`timescale 1ns / 1ps

package mf_pkg;

  // Image geometry and field widths
  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 1024;
  localparam int PIXEL_BITS   = 8;
  localparam int COL_BITS     = $clog2(MAX_WIDTH);
  localparam int ROW_BITS     = $clog2(MAX_HEIGHT);
  localparam int CFG_BITS     = 11;
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Queue between front end and back end
  localparam int Q_DEPTH    = 8;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // One queued word: everything needed to emit the results of one input
  typedef struct packed {
    pix_t                med;       // median of the window
    pix_t                w11;       // window centre
    pix_t                w12;       // middle row, newest column
    pix_t                w21;       // bottom row, middle column
    pix_t                w22;       // bottom row, newest column
    logic [ROW_BITS-1:0] row;       // row of the input
    logic [COL_BITS-1:0] col;       // column of the input
    logic                is_int;    // first result is an interior pixel
    logic                col_end;   // input sits in the last column
    logic                last_row;  // input sits in the last row
  } q_word_t;

  typedef struct packed {
    logic    valid;
    q_word_t word;
  } q_push_t;

endpackage

/* rtl/mf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/mf_front.sv */
// Front end of the median filter: frame position counters, configuration,
// line stores, 3x3 window and the pipelined median network.
// Depends on mf_pkg and mf_ram.
`timescale 1ns / 1ps

module mf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [mf_pkg::PIXEL_BITS-1:0]    in_pixel_in,
  input  logic                             cfg_wr_en,
  input  logic [mf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mf_pkg::CFG_BITS-1:0]      cfg_data,
  input  logic [mf_pkg::Q_CNT_BITS-1:0]    q_count,
  output mf_pkg::q_push_t                  push
);

  typedef struct packed {
    logic [mf_pkg::ROW_BITS-1:0] row;
    logic [mf_pkg::COL_BITS-1:0] col;
    logic                        has_out;
    logic                        is_int;
    logic                        col_end;
    logic                        last_row;
  } meta_t;

  typedef struct packed {
    mf_pkg::pix_t lo;
    mf_pkg::pix_t mid;
    mf_pkg::pix_t hi;
  } trio_t;

  typedef struct packed {
    mf_pkg::pix_t w11;
    mf_pkg::pix_t w12;
    mf_pkg::pix_t w21;
    mf_pkg::pix_t w22;
  } edge_pix_t;

  localparam logic [mf_pkg::CFG_BITS-1:0] MAX_W_C = mf_pkg::CFG_BITS'(mf_pkg::MAX_WIDTH);
  localparam logic [mf_pkg::CFG_BITS-1:0] MAX_H_C = mf_pkg::CFG_BITS'(mf_pkg::MAX_HEIGHT);
  localparam logic [mf_pkg::CFG_BITS-1:0] MIN_C   = mf_pkg::CFG_BITS'(3);

  // Clamp a size to [3, hi] and return size - 1
  function automatic logic [mf_pkg::COL_BITS-1:0] size_last(
    input logic [mf_pkg::CFG_BITS-1:0] v,
    input logic [mf_pkg::CFG_BITS-1:0] hi
  );
    logic [mf_pkg::CFG_BITS-1:0] s;
    begin
      if (v < MIN_C) begin
        s = MIN_C;
      end else if (v > hi) begin
        s = hi;
      end else begin
        s = v;
      end
      s = s - mf_pkg::CFG_BITS'(1);
      return s[mf_pkg::COL_BITS-1:0];
    end
  endfunction

  function automatic mf_pkg::pix_t pmin(input mf_pkg::pix_t a, input mf_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf_pkg::pix_t pmax(input mf_pkg::pix_t a, input mf_pkg::pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic trio_t sort3(input mf_pkg::pix_t a, input mf_pkg::pix_t b,
                                  input mf_pkg::pix_t c);
    trio_t t;
    mf_pkg::pix_t l1;
    mf_pkg::pix_t h1;
    begin
      l1    = pmin(a, b);
      h1    = pmax(a, b);
      t.hi  = pmax(h1, c);
      t.lo  = pmin(l1, c);
      t.mid = pmax(l1, pmin(h1, c));
      return t;
    end
  endfunction

  function automatic mf_pkg::pix_t med3(input mf_pkg::pix_t a, input mf_pkg::pix_t b,
                                        input mf_pkg::pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

  // Configuration and position state
  logic [mf_pkg::COL_BITS-1:0] wlast_r, wlast_nxt;
  logic [mf_pkg::ROW_BITS-1:0] hlast_r, hlast_nxt;
  logic [mf_pkg::ROW_BITS-1:0] row_r, row_nxt;
  logic [mf_pkg::COL_BITS-1:0] col_r, col_nxt;

  // Pipeline stage registers
  logic         v1_r, v2_r, v3_r, v4_r;
  mf_pkg::pix_t pix1_r;
  meta_t        meta1_r, meta2_r, meta3_r, meta4_r;
  meta_t        meta1_cls;
  mf_pkg::pix_t win_r   [3][3];
  mf_pkg::pix_t win_nxt [3][3];
  trio_t        srt3_r  [3];
  edge_pix_t    edge3_r, edge4_r;
  mf_pkg::pix_t lomax4_r, midmed4_r, himin4_r;

  // Line store ports
  mf_pkg::pix_t line_a_rd, line_b_rd;
  logic         accept;
  logic [2:0]   occupancy;
  logic [mf_pkg::Q_CNT_BITS:0] in_flight;

  // Credit check: every item in the pipe may still need a queue slot
  assign occupancy = 3'(v1_r) + 3'(v2_r) + 3'(v3_r) + 3'(v4_r);
  assign in_flight = (mf_pkg::Q_CNT_BITS+1)'(q_count) + (mf_pkg::Q_CNT_BITS+1)'(occupancy);
  assign in_stall  = (in_flight >= (mf_pkg::Q_CNT_BITS+1)'(mf_pkg::Q_DEPTH));
  assign accept    = in_valid && !in_stall;

  // Advance position, restart on any known register write
  always_comb begin
    wlast_nxt = wlast_r;
    hlast_nxt = hlast_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    if (cfg_wr_en && (cfg_index == mf_pkg::REG_FRAME_WIDTH ||
                      cfg_index == mf_pkg::REG_FRAME_HEIGHT)) begin
      if (cfg_index == mf_pkg::REG_FRAME_WIDTH) begin
        wlast_nxt = size_last(cfg_data, MAX_W_C);
      end else begin
        hlast_nxt = size_last(cfg_data, MAX_H_C);
      end
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + mf_pkg::ROW_BITS'(1);
      end else begin
        col_nxt = col_r + mf_pkg::COL_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r <= mf_pkg::COL_BITS'(639);
      hlast_r <= mf_pkg::ROW_BITS'(479);
      row_r   <= '0;
      col_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
    end else begin
      wlast_r <= wlast_nxt;
      hlast_r <= hlast_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      v1_r    <= accept;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
    end
  end

  // Line stores: read at acceptance, rotate in the following cycle
  mf_ram #(.WIDTH(mf_pkg::PIXEL_BITS), .DEPTH(mf_pkg::MAX_WIDTH)) u_line_a (
    .clk     (clk),
    .wr_en   (v1_r),
    .wr_addr (meta1_r.col),
    .wr_data (pix1_r),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (line_a_rd)
  );

  mf_ram #(.WIDTH(mf_pkg::PIXEL_BITS), .DEPTH(mf_pkg::MAX_WIDTH)) u_line_b (
    .clk     (clk),
    .wr_en   (v1_r),
    .wr_addr (meta1_r.col),
    .wr_data (line_a_rd),
    .rd_en   (accept),
    .rd_addr (col_r),
    .rd_data (line_b_rd)
  );

  // Classify the results this word will cause
  always_comb begin
    meta1_cls          = meta1_r;
    meta1_cls.has_out  = (meta1_r.row != '0) && (meta1_r.col != '0);
    meta1_cls.is_int   = (meta1_r.row >= mf_pkg::ROW_BITS'(2)) &&
                         (meta1_r.col >= mf_pkg::COL_BITS'(2));
    meta1_cls.col_end  = (meta1_r.col == wlast_r);
    meta1_cls.last_row = (meta1_r.row == hlast_r);
  end

  // Shift the window left and load the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = line_b_rd;
    win_nxt[1][2] = line_a_rd;
    win_nxt[2][2] = pix1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (v1_r) begin
      win_r <= win_nxt;
    end
  end

  // Payload stages: capture, sort rows, reduce
  always_ff @(posedge clk) begin
    pix1_r        <= in_pixel_in;
    meta1_r.row   <= row_r;
    meta1_r.col   <= col_r;
    meta1_r.has_out  <= 1'b0;
    meta1_r.is_int   <= 1'b0;
    meta1_r.col_end  <= 1'b0;
    meta1_r.last_row <= 1'b0;
    meta2_r       <= meta1_cls;
    meta3_r       <= meta2_r;
    meta4_r       <= meta3_r;
    for (int i = 0; i < 3; i++) begin
      srt3_r[i] <= sort3(win_r[i][0], win_r[i][1], win_r[i][2]);
    end
    edge3_r.w11   <= win_r[1][1];
    edge3_r.w12   <= win_r[1][2];
    edge3_r.w21   <= win_r[2][1];
    edge3_r.w22   <= win_r[2][2];
    edge4_r       <= edge3_r;
    lomax4_r      <= pmax(pmax(srt3_r[0].lo, srt3_r[1].lo), srt3_r[2].lo);
    midmed4_r     <= med3(srt3_r[0].mid, srt3_r[1].mid, srt3_r[2].mid);
    himin4_r      <= pmin(pmin(srt3_r[0].hi, srt3_r[1].hi), srt3_r[2].hi);
  end

  // Final median and push into the queue
  always_comb begin
    push.valid         = v4_r && meta4_r.has_out;
    push.word.med      = med3(lomax4_r, midmed4_r, himin4_r);
    push.word.w11      = edge4_r.w11;
    push.word.w12      = edge4_r.w12;
    push.word.w21      = edge4_r.w21;
    push.word.w22      = edge4_r.w22;
    push.word.row      = meta4_r.row;
    push.word.col      = meta4_r.col;
    push.word.is_int   = meta4_r.is_int;
    push.word.col_end  = meta4_r.col_end;
    push.word.last_row = meta4_r.last_row;
  end

endmodule

/* rtl/mf_queue.sv */
// Short first-word-fall-through queue between front end and back end.
// Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mf_pkg::q_push_t               push,
  input  logic                          pop,
  output logic                          head_valid,
  output mf_pkg::q_word_t               head,
  output logic [mf_pkg::Q_CNT_BITS-1:0] count
);

  mf_pkg::q_word_t                 mem [mf_pkg::Q_DEPTH];
  logic [mf_pkg::Q_PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [mf_pkg::Q_PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [mf_pkg::Q_CNT_BITS-1:0]   count_r, count_nxt;
  logic                            do_pop;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign count      = count_r;
  assign do_pop     = pop && head_valid;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push.valid ? wr_ptr_r + mf_pkg::Q_PTR_BITS'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + mf_pkg::Q_PTR_BITS'(1) : rd_ptr_r;
    count_nxt  = count_r + mf_pkg::Q_CNT_BITS'(push.valid) - mf_pkg::Q_CNT_BITS'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the word
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr_r] <= push.word;
    end
  end

endmodule

/* rtl/mf_back.sv */
// Back end of the median filter: expands each queued word into its one to
// four result words and drives the output register. Depends on mf_pkg.
`timescale 1ns / 1ps

module mf_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  mf_pkg::q_word_t               head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mf_pkg::PIXEL_BITS-1:0] out_pixel_out,
  output logic [mf_pkg::ROW_BITS-1:0]   out_row,
  output logic [mf_pkg::COL_BITS-1:0]   out_col,
  output logic                          out_last_of_run,
  output logic                          out_frame_done
);

  // Result slots of one word
  localparam logic [1:0] SLOT_MAIN      = 2'd0;  // (r-1, c-1)
  localparam logic [1:0] SLOT_ROW_END   = 2'd1;  // (r-1, c) at end of row
  localparam logic [1:0] SLOT_LAST_ROW  = 2'd2;  // (r, c-1) on last row
  localparam logic [1:0] SLOT_CORNER    = 2'd3;  // (r, c) at frame end

  logic [1:0]                    sel_r, sel_nxt;
  logic                          out_valid_r;
  mf_pkg::pix_t                  pix_r;
  logic [mf_pkg::ROW_BITS-1:0]   row_r;
  logic [mf_pkg::COL_BITS-1:0]   col_r;
  logic                          last_r, done_r;
  logic [3:0]                    present;
  logic                          found;
  logic [1:0]                    next_slot;
  logic                          is_last;
  logic                          load;
  mf_pkg::pix_t                  slot_pix;
  logic [mf_pkg::ROW_BITS-1:0]   slot_row;
  logic [mf_pkg::COL_BITS-1:0]   slot_col;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign pop  = load && is_last;

  // Find the next slot the word still owes
  always_comb begin
    present   = {head.last_row & head.col_end, head.last_row, head.col_end, 1'b1};
    found     = 1'b0;
    next_slot = SLOT_MAIN;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > sel_r && present[i]) begin
        found     = 1'b1;
        next_slot = 2'(i);
      end
    end
    is_last = !found;
    sel_nxt = is_last ? SLOT_MAIN : next_slot;
  end

  // Select value and position for the current slot
  always_comb begin
    case (sel_r)
      SLOT_MAIN: begin
        slot_pix = head.is_int ? head.med : head.w11;
        slot_row = head.row - mf_pkg::ROW_BITS'(1);
        slot_col = head.col - mf_pkg::COL_BITS'(1);
      end
      SLOT_ROW_END: begin
        slot_pix = head.w12;
        slot_row = head.row - mf_pkg::ROW_BITS'(1);
        slot_col = head.col;
      end
      SLOT_LAST_ROW: begin
        slot_pix = head.w21;
        slot_row = head.row;
        slot_col = head.col - mf_pkg::COL_BITS'(1);
      end
      SLOT_CORNER: begin
        slot_pix = head.w22;
        slot_row = head.row;
        slot_col = head.col;
      end
      default: begin
        slot_pix = head.w11;
        slot_row = head.row;
        slot_col = head.col;
      end
    endcase
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= SLOT_MAIN;
    end else if (load) begin
      out_valid_r <= 1'b1;
      sel_r       <= sel_nxt;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      pix_r  <= slot_pix;
      row_r  <= slot_row;
      col_r  <= slot_col;
      last_r <= is_last;
      done_r <= (sel_r == SLOT_CORNER);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_out   = pix_r;
  assign out_row         = row_r;
  assign out_col         = col_r;
  assign out_last_of_run = last_r;
  assign out_frame_done  = done_r;

endmodule

/* rtl/median_filter_3x3.sv */
// Streaming 3x3 median filter, top level. Takes one pixel word per cycle
// while in_stall is low. The first result of a word passes the capture
// register, window, two sort stages, queue and output register; line
// stores are read at acceptance. A word that causes several results
// sends them one after another through the single output register.
// Reset: 640 x 480 frame, position (0,0), window zero; line stores not cleared.
`timescale 1ns / 1ps

module median_filter_3x3 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mf_pkg::PIXEL_BITS-1:0]   in_pixel_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [mf_pkg::PIXEL_BITS-1:0]   out_pixel_out,
  output logic [mf_pkg::ROW_BITS-1:0]     out_row,
  output logic [mf_pkg::COL_BITS-1:0]     out_col,
  output logic                            out_last_of_run,
  output logic                            out_frame_done,
  input  logic                            cfg_wr_en,
  input  logic [mf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [mf_pkg::CFG_BITS-1:0]     cfg_data
);

  mf_pkg::q_push_t                 push;
  mf_pkg::q_word_t                 head;
  logic                            head_valid;
  logic                            pop;
  logic [mf_pkg::Q_CNT_BITS-1:0]   q_count;

  // Front end: position, line stores, window, median
  mf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_in (in_pixel_in),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_count     (q_count),
    .push        (push)
  );

  // Decoupling queue
  mf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  // Back end: result expansion and output register
  mf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done)
  );

endmodule

/* rtl/mf_checker.sv */
// Port-level checks for the median filter, bound to the top level.
// Depends on mf_pkg and median_filter_3x3.
`timescale 1ns / 1ps

module mf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [mf_pkg::PIXEL_BITS-1:0]   out_pixel_out,
  input logic [mf_pkg::ROW_BITS-1:0]     out_row,
  input logic [mf_pkg::COL_BITS-1:0]     out_col,
  input logic                            out_last_of_run,
  input logic                            out_frame_done
);

  // Output register is empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) &&
    $stable(out_row) && $stable(out_col) && $stable(out_last_of_run))
    else $error("stalled result word changed");

  // The frame's last pixel closes the run of its input word
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_run)
    else $error("frame end without end of run");

  // The frame's last pixel never sits in row or column zero
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> (out_row != '0) && (out_col != '0))
    else $error("frame end at an impossible position");

  // Results of one input word follow without a gap
  a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a run of results");

endmodule

bind median_filter_3x3 mf_checker u_mf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_pixel_out   (out_pixel_out),
  .out_row         (out_row),
  .out_col         (out_col),
  .out_last_of_run (out_last_of_run),
  .out_frame_done  (out_frame_done)
);

/* tb/sv/median_filter_3x3_tb.sv */
// Self-checking testbench for median_filter_3x3: a scoreboard class predicts
// every filtered pixel from the accepted input words and the frame registers.
// Depends on mf_pkg and the median_filter_3x3 RTL only.
`timescale 1ns / 1ps

module median_filter_3x3_tb;
  import mf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam int unsigned REPORT_MAX    = 10;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_3 = 2'd3;

  // Pixel content styles
  localparam int STYLE_UNIFORM = 0;
  localparam int STYLE_EXTREME = 1;
  localparam int STYLE_NARROW  = 2;

  // Two 3x3 frames: corners and mid values, then single bit patterns
  localparam pix_t DIRECTED_PX [18] = '{
    8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
    8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA, 8'h55
  };

  typedef struct packed {
    pix_t                pix;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
    logic                done;
  } filt_result_t;

  // Predicts the filtered pixel stream and checks it in order
  class median_scoreboard;
    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] height_reg;
    pix_t                row_above     [MAX_WIDTH];
    pix_t                row_two_above [MAX_WIDTH];
    pix_t                win [3][3];
    int unsigned         row_pos;
    int unsigned         col_pos;
    filt_result_t        expected_q [$];
    int unsigned         mismatches;
    int unsigned         words_seen;
    int unsigned         results_seen;
    int unsigned         frames_seen;

    function new();
      width_reg  = 11'd640;
      height_reg = 11'd480;
      foreach (row_above[i]) begin
        row_above[i]     = '0;
        row_two_above[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      row_pos      = 0;
      col_pos      = 0;
      mismatches   = 0;
      words_seen   = 0;
      results_seen = 0;
      frames_seen  = 0;
    endfunction

    function int unsigned clamp_dim(logic [CFG_BITS-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return clamp_dim(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return clamp_dim(height_reg, MAX_HEIGHT);
    endfunction

    // Any known register restarts the frame; stores and window are kept
    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
      if (idx == REG_FRAME_WIDTH) width_reg = data;
      else if (idx == REG_FRAME_HEIGHT) height_reg = data;
      else return;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function pix_t window_median();
      pix_t sorted [9];
      pix_t v;
      int   j;
      for (int i = 0; i < 9; i++) sorted[i] = win[i / 3][i % 3];
      for (int i = 1; i < 9; i++) begin
        v = sorted[i];
        j = i - 1;
        while (j >= 0 && sorted[j] > v) begin
          sorted[j + 1] = sorted[j];
          j--;
        end
        sorted[j + 1] = v;
      end
      return sorted[4];
    endfunction

    function void note_pixel(pix_t p);
      int unsigned  w, h, r, c, n;
      int unsigned  orow [4];
      int unsigned  ocol [4];
      bit           interior;
      pix_t         med;
      filt_result_t res;
      w = eff_width();
      h = eff_height();
      r = row_pos;
      c = col_pos;
      n = 0;
      words_seen++;

      // Shift the window left and load the newest column
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = row_two_above[c];
      win[1][2] = row_above[c];
      win[2][2] = p;
      row_two_above[c] = row_above[c];
      row_above[c]     = p;
      med = window_median();

      // Pixels whose neighbourhood this word completes
      if (r >= 1 && c >= 1) begin
        orow[n] = r - 1; ocol[n] = c - 1; n++;
        if (c == w - 1) begin
          orow[n] = r - 1; ocol[n] = c; n++;
        end
        if (r == h - 1) begin
          orow[n] = r; ocol[n] = c - 1; n++;
          if (c == w - 1) begin
            orow[n] = r; ocol[n] = c; n++;
          end
        end
      end

      for (int k = 0; k < n; k++) begin
        interior = orow[k] >= 1 && orow[k] <= h - 2 && ocol[k] >= 1 && ocol[k] <= w - 2;
        res.pix  = interior ? med : win[(orow[k] + 2 - r) % 3][(ocol[k] + 2 - c) % 3];
        res.row  = orow[k][ROW_BITS-1:0];
        res.col  = ocol[k][COL_BITS-1:0];
        res.last = (k == n - 1);
        res.done = (orow[k] == h - 1) && (ocol[k] == w - 1);
        expected_q.insert(expected_q.size(), res);
      end

      // Advance the raster position
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    function void check_result(filt_result_t got);
      filt_result_t want;
      results_seen++;
      if (got.done) frames_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected word pix=%02h row=%0d col=%0d last=%b done=%b",
                   $time, got.pix, got.row, got.col, got.last, got.done);
        return;
      end
      want = expected_q.pop_front();
      if (got.pix !== want.pix || got.row !== want.row || got.col !== want.col ||
          got.last !== want.last || got.done !== want.done) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: exp %02h r%0d c%0d l%b d%b, got %02h r%0d c%0d l%b d%b",
                   $time, want.pix, want.row, want.col, want.last, want.done,
                   got.pix, got.row, got.col, got.last, got.done);
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  pix_t                    in_pixel_in = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  pix_t                    out_pixel_out;
  logic [ROW_BITS-1:0]     out_row;
  logic [COL_BITS-1:0]     out_col;
  logic                    out_last_of_run;
  logic                    out_frame_done;
  logic                    cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]     cfg_data = '0;

  median_scoreboard sb;
  bit               idle_on = 1'b1;
  int unsigned      stall_left = 0;
  int unsigned      cycle_count = 0;
  int unsigned      phase_count = 0;

  median_filter_3x3 u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_in     (in_pixel_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_out   (out_pixel_out),
    .out_row         (out_row),
    .out_col         (out_col),
    .out_last_of_run (out_last_of_run),
    .out_frame_done  (out_frame_done),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 99) < 15) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Note accepted pixels and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_pixel(in_pixel_in);
      if (out_valid && !out_stall)
        sb.check_result(filt_result_t'{out_pixel_out, out_row, out_col,
                                       out_last_of_run, out_frame_done});
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, sb.expected_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic pix_t pick_pixel(int style);
    case (style)
      STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      STYLE_NARROW:  return 8'h78 + 8'($urandom_range(0, 7));
      default:       return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Present one word, hold it until taken; called and returns at a falling edge
  task automatic send_pixel(input pix_t p);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_valid    = 1'b1;
    in_pixel_in = p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pixels(input int unsigned count, input int style);
    for (int unsigned i = 0; i < count; i++) send_pixel(pick_pixel(style));
  endtask

  // Drain all expected results, then let words with no result clear the pipe
  task automatic settle();
    in_valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] data);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [CFG_BITS-1:0] pick_dim(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return CFG_BITS'($urandom_range(0, 2));
      1:       return CFG_BITS'($urandom_range(hi + 1, hi + 6));
      default: return CFG_BITS'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    int unsigned random_words;
    int unsigned frame_words;
    int unsigned count;
    int          style;

    sb = new();
    random_words = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Sizes below the minimum act as 3x3; two full frames of corner values
    phase_count++;
    program_reg(REG_FRAME_WIDTH, 11'd2);
    program_reg(REG_FRAME_HEIGHT, 11'd0);
    foreach (DIRECTED_PX[i]) send_pixel(DIRECTED_PX[i]);

    // Writes to spare indexes mid-frame must not restart the frame
    send_pixels(4, STYLE_UNIFORM);
    settle();
    program_reg(REG_SPARE_3, 11'h7FF);
    program_reg(REG_SPARE_2, 11'h2AA);
    send_pixels(5, STYLE_UNIFORM);

    // Oversized width clamps to the full line; the start of its first row
    settle();
    phase_count++;
    program_reg(REG_FRAME_WIDTH, 11'h7FF);
    program_reg(REG_FRAME_HEIGHT, 11'd5);
    send_pixels(8, STYLE_UNIFORM);

    // Random frame sizes, mostly whole frames, some cut short by a restart
    while (random_words < RANDOM_ITEMS) begin
      settle();
      phase_count++;
      idle_on = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0: program_reg(REG_FRAME_WIDTH, pick_dim(3, 10));
        1: program_reg(REG_FRAME_HEIGHT, pick_dim(3, 6));
        default: begin
          program_reg(REG_FRAME_WIDTH, pick_dim(3, 10));
          program_reg(REG_FRAME_HEIGHT, pick_dim(3, 6));
        end
      endcase
      frame_words = sb.eff_width() * sb.eff_height();
      if ($urandom_range(0, 9) < 7)
        count = frame_words * ((frame_words > 60) ? 1 : $urandom_range(1, 2));
      else
        count = $urandom_range(1, frame_words - 1);
      if (count > RANDOM_ITEMS - random_words) count = RANDOM_ITEMS - random_words;
      style = $urandom_range(0, 9) < 6 ? STYLE_UNIFORM :
              ($urandom_range(0, 1) ? STYLE_EXTREME : STYLE_NARROW);
      send_pixels(count, style);
      random_words += count;
    end

    // Tallest frame, narrowest width: its first eight rows
    settle();
    phase_count++;
    idle_on = 1'b1;
    program_reg(REG_FRAME_WIDTH, 11'd3);
    program_reg(REG_FRAME_HEIGHT, 11'd1024);
    send_pixels(3 * 8, STYLE_UNIFORM);

    // Closing frame with both sides running flat out
    settle();
    phase_count++;
    idle_on = 1'b0;
    program_reg(REG_FRAME_WIDTH, 11'd5);
    program_reg(REG_FRAME_HEIGHT, 11'd4);
    send_pixels(20, STYLE_UNIFORM);
    settle();

    $display("Run covered %0d pixel words and %0d results in %0d phases, %0d frame ends seen,",
             sb.words_seen, sb.results_seen, phase_count, sb.frames_seen);
    $display("sizes from the 3x3 minimum to the 1024 limits, partial frames too; %0d mismatches",
             sb.mismatches);
    if (sb.expected_q.size() != 0)
      $display("%0d expected results never arrived", sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
